// ===== rtl/fsp_pkg.sv =====
// shared types and constants for the windowed frame splitter
`timescale 1ns / 1ps
`default_nettype none
package fsp_pkg;

	localparam int SAMPLE_W = 16;
	localparam int POS_W = 6;
	localparam int STORE_DEPTH = 64;
	localparam int COUNT_W = 7;
	localparam int FRAME_NUM_W = 16;
	localparam int COEF_W = 17;
	localparam int PROD_W = SAMPLE_W + COEF_W + 1;
	localparam int STEP_W = 7;
	localparam int KIND_W = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_STEP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_KIND = 1'b1;

	localparam logic [KIND_W-1:0] KIND_RECT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_HANN = 2'd1;
	localparam logic [KIND_W-1:0] KIND_HAMMING = 2'd2;

	localparam logic [COEF_W-1:0] COEF_UNITY = 17'd32768;

	localparam longint Q30_ONE = 64'sd1073741824;
	localparam longint PI_Q30 = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;

	typedef enum logic [1:0] {
		WIN_RECT = 2'd0,
		WIN_HANN = 2'd1,
		WIN_HAMMING = 2'd2
	} win_row_t;

	typedef struct packed {
		logic [STEP_W-1:0] frame_step;
		logic [KIND_W-1:0] window_kind;
	} cfg_t;

endpackage
`default_nettype wire

// ===== rtl/fsp_coef_rom.sv =====
// window coefficient table built at elaboration from the frame length
`timescale 1ns / 1ps
`default_nettype none
module fsp_coef_rom
	import fsp_pkg::*;
#(
	parameter int FRAME_LEN = 64
) (
	input  win_row_t              row,
	input  logic [POS_W-1:0]      idx,
	output logic [COEF_W-1:0]     coef
);

	localparam longint D = (FRAME_LEN > 1) ? longint'(FRAME_LEN - 1) : 64'sd1;

	logic [COEF_W-1:0] hann_c [FRAME_LEN];
	logic [COEF_W-1:0] hamm_c [FRAME_LEN];

	for (genvar gi = 0; gi < FRAME_LEN; gi++) begin : g_col
		localparam longint K = (2 * longint'(gi) > D) ? D - longint'(gi) : longint'(gi);
		localparam longint A0 = (2 * PI_Q30 * K + D / 2) / D;
		localparam bit NEG = (A0 > HALF_PI_Q30);
		localparam longint A = NEG ? (PI_Q30 - A0) : A0;
		localparam longint A2 = (A * A + 64'sd536870912) >>> 30;
		localparam longint R1 = Q30_ONE - ((A2 * Q30_ONE) >>> 30) / 132;
		localparam longint R2 = Q30_ONE - ((A2 * R1) >>> 30) / 90;
		localparam longint R3 = Q30_ONE - ((A2 * R2) >>> 30) / 56;
		localparam longint R4 = Q30_ONE - ((A2 * R3) >>> 30) / 30;
		localparam longint R5 = Q30_ONE - ((A2 * R4) >>> 30) / 12;
		localparam longint R6 = Q30_ONE - ((A2 * R5) >>> 30) / 2;
		localparam longint RC = (R6 < 0) ? 64'sd0 : R6;
		localparam longint C = NEG ? -RC : RC;
		localparam longint HANN = (Q30_ONE - C + 64'sd32768) >>> 16;
		localparam longint HAMM = (54 * Q30_ONE - 46 * C + 64'sd1638400) / 64'sd3276800;
		assign hann_c[gi] = HANN[COEF_W-1:0];
		assign hamm_c[gi] = HAMM[COEF_W-1:0];
	end

	always_comb begin
		case (row)
			WIN_HANN: coef = hann_c[idx];
			WIN_HAMMING: coef = hamm_c[idx];
			default: coef = COEF_UNITY;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/fsp_win_mul.sv =====
// shared multiplier with round to nearest and saturation to q1.15
`timescale 1ns / 1ps
`default_nettype none
module fsp_win_mul
	import fsp_pkg::*;
(
	input  logic                       clk,
	input  logic                       en,
	input  logic signed [SAMPLE_W-1:0] samp,
	input  logic [COEF_W-1:0]          coef,
	output logic signed [SAMPLE_W-1:0] value
);

	localparam int SUM_W = PROD_W + 1;
	localparam int Q_W = SUM_W - 15;

	logic signed [PROD_W-1:0] prod_s2;
	logic signed [SUM_W-1:0]  rnd_sum;
	logic signed [Q_W-1:0]    quot;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= PROD_W'(samp) * $signed({1'b0, coef});
		end
	end

	always_comb begin
		rnd_sum = SUM_W'(prod_s2) + SUM_W'(16384);
		quot = Q_W'(rnd_sum >>> 15);
		if (quot > Q_W'(32767)) begin
			value = 16'sh7fff;
		end else if (quot < -Q_W'(32768)) begin
			value = 16'sh8000;
		end else begin
			value = quot[SAMPLE_W-1:0];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/fsp_seq.sv =====
// sample store, frame countdown and the sequencer that streams a windowed frame
`timescale 1ns / 1ps
`default_nettype none
module fsp_seq
	import fsp_pkg::*;
#(
	parameter int FRAME_LEN = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfg_t                          cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_W-1:0]    sample,
	input  logic                          start_of_signal,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [FRAME_NUM_W-1:0]        frame_number,
	output logic [POS_W-1:0]              position,
	output logic signed [SAMPLE_W-1:0]    windowed_value,
	output logic                          last_of_frame
);

	localparam logic [COUNT_W-1:0] FL_CNT = COUNT_W'(FRAME_LEN);
	localparam logic [POS_W-1:0] FL_POS = POS_W'(FRAME_LEN);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic signed [SAMPLE_W-1:0] store_mem [STORE_DEPTH];

	logic [POS_W-1:0]       wp_q;
	logic [COUNT_W-1:0]     cnt_q;
	logic [FRAME_NUM_W-1:0] fc_q;
	logic [FRAME_NUM_W-1:0] emit_frame_q;
	win_row_t               row_q;
	logic [COUNT_W-1:0]     jcnt_q;

	logic                       v_s1, v_s2;
	logic [POS_W-1:0]           j_s1, j_s2;
	logic signed [SAMPLE_W-1:0] samp_s1;

	logic                       out_valid_q;
	logic [POS_W-1:0]           out_pos_q;
	logic                       out_last_q;
	logic signed [SAMPLE_W-1:0] out_value_q;

	logic                       accept;
	logic [COUNT_W-1:0]         cnt_base;
	logic [FRAME_NUM_W-1:0]     fc_base;
	logic                       frame_done;
	logic [COUNT_W-1:0]         step_eff;
	win_row_t                   row_sel;
	logic                       adv;
	logic                       issue;
	logic [POS_W-1:0]           rd_addr;
	logic [COEF_W-1:0]          coef;
	logic signed [SAMPLE_W-1:0] mul_value;
	logic                       drained;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign cnt_base = start_of_signal ? FL_CNT : cnt_q;
	assign fc_base = start_of_signal ? '0 : fc_q;
	assign frame_done = (cnt_base <= COUNT_W'(1));
	assign step_eff = (cfg.frame_step == '0) ? FL_CNT : cfg.frame_step;

	always_comb begin
		case (cfg.window_kind)
			KIND_HANN: row_sel = WIN_HANN;
			KIND_HAMMING: row_sel = WIN_HAMMING;
			default: row_sel = WIN_RECT;
		endcase
	end

	assign adv = !out_valid_q || out_ready;
	assign issue = (state_q == ST_EMIT) && (jcnt_q < FL_CNT);
	assign rd_addr = wp_q + jcnt_q[POS_W-1:0] - FL_POS;
	assign drained = (jcnt_q == FL_CNT) && !v_s1 && !v_s2 && !out_valid_q;

	fsp_coef_rom #(
		.FRAME_LEN(FRAME_LEN)
	) u_coef_rom (
		.row (row_q),
		.idx (j_s1),
		.coef(coef)
	);

	fsp_win_mul u_win_mul (
		.clk  (clk),
		.en   (adv),
		.samp (samp_s1),
		.coef (coef),
		.value(mul_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wp_q <= '0;
			cnt_q <= FL_CNT;
			fc_q <= '0;
			jcnt_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid_q <= 1'b0;
			emit_frame_q <= '0;
			out_pos_q <= '0;
			out_last_q <= 1'b0;
			out_value_q <= '0;
		end else begin
			if (adv) begin
				v_s1 <= issue;
				v_s2 <= v_s1;
				out_valid_q <= v_s2;
				out_pos_q <= j_s2;
				out_last_q <= (j_s2 == LAST_POS);
				out_value_q <= mul_value;
				if (issue) begin
					jcnt_q <= jcnt_q + COUNT_W'(1);
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						wp_q <= wp_q + POS_W'(1);
						if (frame_done) begin
							fc_q <= fc_base + FRAME_NUM_W'(1);
							cnt_q <= step_eff;
							jcnt_q <= '0;
							emit_frame_q <= fc_base;
							state_q <= ST_EMIT;
						end else begin
							fc_q <= fc_base;
							cnt_q <= cnt_base - COUNT_W'(1);
						end
					end
				end
				ST_EMIT: begin
					if (drained) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			store_mem[wp_q] <= sample;
		end
		if (adv && issue) begin
			samp_s1 <= store_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && frame_done) begin
			row_q <= row_sel;
		end
		if (adv) begin
			j_s1 <= jcnt_q[POS_W-1:0];
			j_s2 <= j_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign frame_number = emit_frame_q;
	assign position = out_pos_q;
	assign windowed_value = out_value_q;
	assign last_of_frame = out_last_q;

endmodule
`default_nettype wire

// ===== rtl/windowed_frame_splitter_unit.sv =====
// top level of the windowed frame splitter: config registers and sequencer
//
// channel  direction  handshake             payload
// cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
// in       in         in_valid/in_ready     sample, start_of_signal
// out      out        out_valid/out_ready   frame_number, position, windowed_value, last_of_frame
//
// a sample that does not end a frame leaves the input ready for the next sample
// a sample that ends a frame blocks the input until the whole windowed frame has left the output
// one multiplier reads one stored sample per cycle when not stalled, FRAME_LEN products per frame
// out_ready low while out_valid is high stalls the whole read and multiply pipeline in place
// reset loads the countdown with FRAME_LEN and clears frame number, write pointer and config
`timescale 1ns / 1ps
`default_nettype none
module windowed_frame_splitter_unit
	import fsp_pkg::*;
#(
	parameter int FRAME_LEN = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_W-1:0]    sample,
	input  logic                          start_of_signal,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [FRAME_NUM_W-1:0]        frame_number,
	output logic [POS_W-1:0]              position,
	output logic signed [SAMPLE_W-1:0]    windowed_value,
	output logic                          last_of_frame
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FRAME_STEP: cfg_q.frame_step <= cfg_data[STEP_W-1:0];
				CFG_WINDOW_KIND: cfg_q.window_kind <= cfg_data[KIND_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	fsp_seq #(
		.FRAME_LEN(FRAME_LEN)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample         (sample),
		.start_of_signal(start_of_signal),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.frame_number   (frame_number),
		.position       (position),
		.windowed_value (windowed_value),
		.last_of_frame  (last_of_frame)
	);

endmodule
`default_nettype wire

// ===== bench/windowed_frame_splitter_unit_tb.sv =====
// testbench for the windowed frame splitter: directed and random samples checked against a predictor
`timescale 1ns / 1ps
module windowed_frame_splitter_unit_tb
	import fsp_pkg::*;
();

	localparam int FRAME_LEN = 64;
	localparam int STUCK_LIMIT = 20000;
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

	typedef struct packed {
		logic [FRAME_NUM_W-1:0] frame_number;
		logic [POS_W-1:0] position;
		logic signed [SAMPLE_W-1:0] windowed_value;
		logic last_of_frame;
	} frame_result_t;

	class frame_scoreboard;
		localparam int FLEN = FRAME_LEN;
		int unsigned mismatch_count;
		frame_result_t due_results[$];
		int coef_rows [3][STORE_DEPTH];
		logic [STEP_W-1:0] step_setting;
		logic [KIND_W-1:0] kind_setting;
		logic signed [SAMPLE_W-1:0] history [STORE_DEPTH];
		logic [POS_W-1:0] wr_ptr;
		logic [COUNT_W-1:0] to_frame_end;
		logic [FRAME_NUM_W-1:0] frame_count;

		function new();
			longint c;
			int i;
			int r;
			mismatch_count = 0;
			step_setting = '0;
			kind_setting = KIND_RECT;
			wr_ptr = '0;
			to_frame_end = COUNT_W'(FLEN);
			frame_count = '0;
			for (i = 0; i < STORE_DEPTH; i++) begin
				history[i] = '0;
				for (r = 0; r < 3; r++)
					coef_rows[r][i] = 0;
			end
			for (i = 0; i < FLEN && i < STORE_DEPTH; i++) begin
				c = turn_cosine(i);
				coef_rows[WIN_RECT][i] = int'(COEF_UNITY);
				coef_rows[WIN_HANN][i] = int'((Q30_ONE - c + 32768) >>> 16);
				coef_rows[WIN_HAMMING][i] =
					int'((54 * Q30_ONE - 46 * c + 50 * 32768) / (100 * 32768));
			end
		endfunction

		// cosine of column/(FLEN-1) of a turn in Q30, Taylor series folded to a quarter turn
		function longint turn_cosine(int col);
			longint unsigned span, k, ang, ang_sq, prod;
			longint r, divisor;
			bit neg;
			int n;
			span = (FLEN > 1) ? FLEN - 1 : 1;
			k = col;
			neg = 1'b0;
			if (2 * k > span)
				k = span - k;
			ang = (2 * PI_Q30 * k + span / 2) / span;
			if (ang > HALF_PI_Q30) begin
				ang = PI_Q30 - ang;
				neg = 1'b1;
			end
			ang_sq = (ang * ang + (64'd1 << 29)) >> 30;
			r = Q30_ONE;
			for (n = 0; n < 6; n++) begin
				divisor = (12 - 2 * n) * (11 - 2 * n);
				prod = (ang_sq * $unsigned(r)) >> 30;
				r = Q30_ONE - $signed(prod) / divisor;
			end
			if (r < 0)
				r = 0;
			return neg ? -r : r;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_FRAME_STEP)
				step_setting = data[STEP_W-1:0];
			else if (idx == CFG_WINDOW_KIND)
				kind_setting = data[KIND_W-1:0];
		endfunction

		function void note_sample(logic signed [SAMPLE_W-1:0] s, logic sos);
			win_row_t row;
			frame_result_t res;
			longint prod;
			int j;
			int src;
			if (sos) begin
				to_frame_end = COUNT_W'(FLEN);
				frame_count = '0;
			end
			history[wr_ptr] = s;
			wr_ptr = wr_ptr + 1'b1;
			if (to_frame_end > 1) begin
				to_frame_end = to_frame_end - 1'b1;
				return;
			end
			// unused window code falls back to rectangular
			row = (kind_setting > KIND_HAMMING) ? WIN_RECT : win_row_t'(kind_setting);
			for (j = 0; j < FLEN && j < STORE_DEPTH; j++) begin
				src = (int'(wr_ptr) - FLEN + j) & (STORE_DEPTH - 1);
				prod = (longint'(history[src]) * coef_rows[row][j] + 16384) >>> 15;
				if (prod > 32767)
					prod = 32767;
				else if (prod < -32768)
					prod = -32768;
				res.frame_number = frame_count;
				res.position = POS_W'(j);
				res.windowed_value = SAMPLE_W'(prod);
				res.last_of_frame = (j == FLEN - 1);
				due_results.push_back(res);
			end
			frame_count = frame_count + 1'b1;
			to_frame_end = (step_setting == 0) ? COUNT_W'(FLEN) : step_setting;
		endfunction

		function void check_output(logic [FRAME_NUM_W-1:0] fn, logic [POS_W-1:0] pos,
			logic signed [SAMPLE_W-1:0] val, logic last);
			frame_result_t want;
			if (due_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected transfer frame %0d position %0d value %0d",
					$time, fn, pos, val);
				return;
			end
			want = due_results.pop_front();
			if (fn !== want.frame_number) begin
				mismatch_count++;
				$display("%0t: frame_number expected %0d actual %0d",
					$time, want.frame_number, fn);
			end
			if (pos !== want.position) begin
				mismatch_count++;
				$display("%0t: position expected %0d actual %0d", $time, want.position, pos);
			end
			if (val !== want.windowed_value) begin
				mismatch_count++;
				$display("%0t: windowed_value at position %0d expected %0d actual %0d",
					$time, want.position, want.windowed_value, val);
			end
			if (last !== want.last_of_frame) begin
				mismatch_count++;
				$display("%0t: last_of_frame at position %0d expected %0d actual %0d",
					$time, want.position, want.last_of_frame, last);
			end
		endfunction

		function int pending();
			return due_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic start_of_signal;
	logic out_valid;
	logic out_ready;
	logic [FRAME_NUM_W-1:0] frame_number;
	logic [POS_W-1:0] position;
	logic signed [SAMPLE_W-1:0] windowed_value;
	logic last_of_frame;

	int send_idle_pct;
	int recv_idle_pct;
	int stuck_cycles = 0;
	frame_scoreboard sb;

	windowed_frame_splitter_unit #(
		.FRAME_LEN(FRAME_LEN)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.start_of_signal(start_of_signal),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.frame_number(frame_number),
		.position(position),
		.windowed_value(windowed_value),
		.last_of_frame(last_of_frame)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_register(cfg_index, cfg_data);
			if (in_valid && in_ready)
				sb.note_sample(sample, start_of_signal);
			if (out_valid && out_ready)
				sb.check_output(frame_number, position, windowed_value, last_of_frame);
			if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready)) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles >= STUCK_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, stuck_cycles);
				$display("FAIL windowed_frame_splitter_unit");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

	task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic sos);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		sample <= s;
		start_of_signal <= sos;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic write_config(logic [STEP_W-1:0] step, logic [KIND_W-1:0] kind);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_FRAME_STEP;
		cfg_data <= CFG_DATA_W'(step);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_index <= CFG_WINDOW_KIND;
		cfg_data <= {(CFG_DATA_W - KIND_W)'($urandom), kind};
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// hold the input until every frame has drained, then let the sequencer go quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (FRAME_LEN + 8)
			@(posedge clk);
	endtask

	initial begin
		int i;
		int m;
		int g;
		int seg;
		int seg_step [9];
		logic [KIND_W-1:0] seg_kind [9];
		logic [STEP_W-1:0] step;
		logic [KIND_W-1:0] kind;
		logic signed [SAMPLE_W-1:0] corner [5];
		logic signed [SAMPLE_W-1:0] s;
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_FRAME_STEP;
		cfg_data = '0;
		in_valid = 1'b0;
		sample = '0;
		start_of_signal = 1'b0;
		out_ready = 1'b0;
		send_idle_pct = 15;
		recv_idle_pct = 65;
		corner = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
		seg_step = '{1, 127, 0, 2, 65, 64, 0, 1, 100};
		seg_kind = '{KIND_HANN, KIND_SPARE, KIND_HANN, KIND_HAMMING, KIND_RECT,
			KIND_RECT, KIND_RECT, KIND_HAMMING, KIND_HANN};

		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;

		// a few samples, then a restart so the first frame ends on the restart count
		write_config(7'd0, KIND_RECT);
		for (i = 0; i < 3; i++)
			send_sample(SAMPLE_W'($urandom), 1'b0);
		for (i = 0; i < FRAME_LEN; i++)
			send_sample((i < 5) ? corner[i] : SAMPLE_W'($urandom), i == 0);
		settle();

		write_config(7'd1, KIND_HANN);
		for (i = 0; i < 5; i++)
			send_sample(corner[i], 1'b0);
		settle();

		write_config(7'd1, KIND_HAMMING);
		for (i = 0; i < 5; i++)
			send_sample(corner[4 - i], 1'b0);
		settle();

		write_config(7'd2, KIND_SPARE);
		for (i = 0; i < 4; i++)
			send_sample(corner[i], 1'b0);
		settle();

		for (m = 0; m < 3; m++) begin
			case (m)
				0: begin
					send_idle_pct = 15;
					recv_idle_pct = 65;
				end
				1: begin
					send_idle_pct = 65;
					recv_idle_pct = 15;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (g = 0; g < 3; g++) begin
				seg = 3 * m + g;
				step = STEP_W'(seg_step[seg]);
				kind = seg_kind[seg];
				if (seg == 6) begin
					step = STEP_W'($urandom_range(3, 63));
					kind = KIND_W'($urandom_range(0, 3));
				end
				write_config(step, kind);
				for (i = 0; i < 17; i++) begin
					case ($urandom_range(0, 7))
						0: s = 16'h8000;
						1: s = 16'h7fff;
						2: s = SAMPLE_W'(int'($urandom_range(0, 15)) - 8);
						default: s = SAMPLE_W'($urandom);
					endcase
					send_sample(s, $urandom_range(0, 99) < 2);
				end
				settle();
			end
		end

		if (sb.mismatch_count == 0 && sb.pending() == 0)
			$display("PASS windowed_frame_splitter_unit");
		else
			$display("FAIL windowed_frame_splitter_unit");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/fsp_pkg.sv
rtl/fsp_coef_rom.sv
rtl/fsp_win_mul.sv
rtl/fsp_seq.sv
rtl/windowed_frame_splitter_unit.sv
bench/windowed_frame_splitter_unit_tb.sv
